>>> hdl/cwis_pkg.sv
`timescale 1ns / 1ps
// Package for the weighted index sampler: command codes, state encoding,
// generator constants and field widths. No dependencies.
package cwis_pkg;

   localparam int FRAC_W   = 23;
   localparam int VALUE_W  = 24;
   localparam int INDEX_W  = 10;
   localparam int SIZE_W   = 11;
   localparam int SEED_W   = 32;

   localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
   localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_DRAW  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_REDRAW = 5'b00010,
      S_SETUP  = 5'b00100,
      S_SEARCH = 5'b01000,
      S_FINISH = 5'b10000
   } state_type;

endpackage

>>> hdl/cwis_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module cwis_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> hdl/cdf_weighted_index_sampler.sv
`timescale 1ns / 1ps
// Weighted index sampler top level: cumulative weight table in cwis_ram,
// 32-bit LCG and a lower-bound binary search. Depends on cwis_pkg, cwis_ram.
//
// Usage:
//   req channel (valid/stall) carries one word per item. command 0 writes
//   entry_value into the table at entry_index (ignored beyond TABLE_DEPTH);
//   it does not stall the next word, gives no result. command 1 draws: the
//   generator steps (twice when the first fraction is zero) and the table is
//   searched for the first entry not below the fraction.
//   rsp channel (valid/stall) carries sample_index and drawn_fraction.
//   csr channel (valid/ready) writes table_size; always ready; write only
//   while the block is idle.
// Sequence: a taken draw steps the generator (again in S_REDRAW on a zero
//   fraction), sets up in S_SETUP, makes one search step per cycle in
//   S_SEARCH, paced by the table read latency, loads the result in S_FINISH
//   and returns to S_IDLE for the next word. One draw is in flight at a time.
// Reset (synchronous, active high): seed cleared, table_size = 1, no result
//   pending. Table contents are undefined until written.
// Stall: a finished result sits in the rsp register; a following write is
//   still taken, a following draw waits in its last cycle until the result
//   register frees.
module cdf_weighted_index_sampler
   import cwis_pkg::*;
#(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_command,
   input  logic [INDEX_W-1:0]  req_entry_index,
   input  logic [VALUE_W-1:0]  req_entry_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [INDEX_W-1:0]  rsp_sample_index,
   output logic [FRAC_W-1:0]   rsp_drawn_fraction,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [SIZE_W-1:0]   csr_table_size
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int SW = AW + 1;

   state_type          state_ff, state_in;
   logic [SEED_W-1:0]  seed_ff, seed_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [AW-1:0]      lo_ff, lo_in;
   logic [AW-1:0]      hi_ff, hi_in;
   logic [AW-1:0]      mid_ff, mid_in;
   logic               out_valid_ff, out_valid_in;
   logic [INDEX_W-1:0] out_index_ff, out_index_in;
   logic [FRAC_W-1:0]  out_frac_ff, out_frac_in;

   logic [SEED_W-1:0]  seed_step;
   logic [SW-1:0]      size_clamp;
   logic [AW-1:0]      lo_next, hi_next;
   logic [AW:0]        mid_sum;
   logic [AW:0]        step_sum;
   logic               req_accept;
   logic               go_right;

   logic               wr_en;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;

   assign rsp_valid          = out_valid_ff;
   assign rsp_sample_index   = out_index_ff;
   assign rsp_drawn_fraction = out_frac_ff;

   assign seed_step = seed_ff * LCG_MUL + LCG_ADD;

   assign size_clamp = (32'(size_ff) > TABLE_DEPTH) ? SW'(TABLE_DEPTH) : SW'(size_ff);

   assign wr_en = req_accept && (req_command == CMD_WRITE)
                  && (32'(req_entry_index) < TABLE_DEPTH);

   // search step on the entry read last cycle
   assign go_right = ({{(VALUE_W-FRAC_W){1'b0}}, frac_ff} > rd_data);
   assign lo_next  = go_right ? mid_ff + AW'(1) : lo_ff;
   assign hi_next  = go_right ? hi_ff : mid_ff;
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign step_sum = {1'b0, lo_next} + {1'b0, hi_next};

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      size_in      = size_ff;
      frac_in      = frac_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_index_in = out_index_ff;
      out_frac_in  = out_frac_ff;
      rd_en        = 1'b0;
      rd_addr      = mid_sum[AW:1];

      if (csr_valid && csr_ready) begin
         size_in = csr_table_size;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_accept && (req_command == CMD_DRAW)) begin
               frac_in = seed_ff[FRAC_W-1:0];
               seed_in = seed_step;
               lo_in   = '0;
               hi_in   = (size_clamp == '0) ? '0 : AW'(size_clamp - SW'(1));
               if (seed_ff[FRAC_W-1:0] == '0) begin
                  state_in = S_REDRAW;
               end else begin
                  state_in = S_SETUP;
               end
            end
         end
         S_REDRAW: begin
            frac_in  = seed_ff[FRAC_W-1:0];
            seed_in  = seed_step;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid_sum[AW:1];
               mid_in   = mid_sum[AW:1];
               state_in = S_SEARCH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SEARCH: begin
            lo_in = lo_next;
            hi_in = hi_next;
            if (lo_next < hi_next) begin
               rd_en   = 1'b1;
               rd_addr = step_sum[AW:1];
               mid_in  = step_sum[AW:1];
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_index_in = INDEX_W'(lo_ff);
               out_frac_in  = frac_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= '0;
         size_ff      <= SIZE_W'(1);
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         size_ff      <= size_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frac_ff      <= frac_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      out_index_ff <= out_index_in;
      out_frac_ff  <= out_frac_in;
   end

   cwis_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

>>> hdl/cwis_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the weighted index sampler, bound to the top level.
// Depends on cwis_pkg and cdf_weighted_index_sampler.
module cwis_checker
   import cwis_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_command,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [INDEX_W-1:0]  rsp_sample_index,
   input logic [FRAC_W-1:0]   rsp_drawn_fraction
);

   // held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_index)
                                 && $stable(rsp_drawn_fraction))
      else $error("rsp word changed while stalled");

   // a taken draw holds off the next word
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_DRAW) |=> req_stall ##1 req_stall)
      else $error("draw did not hold off input");

   // a new result only appears at the end of a draw
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a draw in progress");

   // writes never stall the input
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_command == CMD_WRITE) |=> !req_stall)
      else $error("write blocked the input");

endmodule

bind cdf_weighted_index_sampler cwis_checker u_checker (.*);

>>> bench/tb_cdf_weighted_index_sampler.sv
`timescale 1ns / 1ps
// Self-checking bench for cdf_weighted_index_sampler: bursty req driver, stalling rsp
// monitor, in-bench LCG and lower-bound predictor. Depends on cwis_pkg and the block.
module tb_cdf_weighted_index_sampler;
   import cwis_pkg::*;

   localparam int TB_DEPTH    = 1024;
   localparam int ITEM_TARGET = 1950;
   localparam int IDLE_GUARD  = 24;
   localparam int DRAIN_LIMIT = 50000;
   localparam int CYCLE_LIMIT = 800000;
   localparam logic [VALUE_W-1:0] ONE_FIXED = 24'h800000;
   localparam logic [VALUE_W-1:0] MAX_VALUE = 24'hFFFFFF;

   typedef struct {
      logic                command;
      logic [INDEX_W-1:0]  entry_index;
      logic [VALUE_W-1:0]  entry_value;
   } req_word_type;

   typedef struct {
      logic [INDEX_W-1:0]  sample_index;
      logic [FRAC_W-1:0]   drawn_fraction;
   } draw_result_type;

   typedef struct packed {
      logic [FRAC_W-1:0]   frac;
      logic [SEED_W-1:0]   seed;
   } draw_step_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_command = CMD_WRITE;
   logic [INDEX_W-1:0]  req_entry_index = '0;
   logic [VALUE_W-1:0]  req_entry_value = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [INDEX_W-1:0]  rsp_sample_index;
   logic [FRAC_W-1:0]   rsp_drawn_fraction;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_table_size = '0;

   req_word_type        pending_words[$];
   draw_result_type     expected_draws[$];
   draw_result_type     oldest_draw;

   // predictor state, updated on accepted words and table_size writes
   logic [VALUE_W-1:0]  weight_mem [TB_DEPTH];
   logic [SEED_W-1:0]   model_seed = '0;
   logic [SIZE_W-1:0]   model_size = 11'd1;

   // stimulus-side shadow, updated as words are queued
   logic [VALUE_W-1:0]  plan_table [TB_DEPTH];
   logic [SEED_W-1:0]   plan_seed = '0;
   int                  items_queued = 0;

   int                  fail_count = 0;
   int                  burst_left = 0;
   int                  gap_left = 0;
   int                  hold_left = 0;
   int                  taken_results = 0;
   int                  stall_mode = 0;
   logic [31:0]         recv_cycle = '0;
   int                  cycle_count = 0;

   cdf_weighted_index_sampler #(.TABLE_DEPTH(TB_DEPTH)) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_entry_index    (req_entry_index),
      .req_entry_value    (req_entry_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sample_index   (rsp_sample_index),
      .rsp_drawn_fraction (rsp_drawn_fraction),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_table_size     (csr_table_size)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // one draw: fraction from the seed, redraw once on zero
   function automatic draw_step_type draw_from(input logic [SEED_W-1:0] s);
      draw_step_type r;
      r.frac = s[FRAC_W-1:0];
      r.seed = s * LCG_MUL + LCG_ADD;
      if (r.frac == '0) begin
         r.frac = r.seed[FRAC_W-1:0];
         r.seed = r.seed * LCG_MUL + LCG_ADD;
      end
      return r;
   endfunction

   function automatic draw_result_type predict_draw();
      draw_result_type r;
      draw_step_type   st;
      int              span;
      int              lo;
      int              hi;
      int              mid;
      st = draw_from(model_seed);
      model_seed = st.seed;
      span = (model_size > TB_DEPTH) ? TB_DEPTH : model_size;
      lo = 0;
      if (span != 0) begin
         hi = span - 1;
         while (lo < hi) begin
            mid = (lo + hi) >> 1;
            if (weight_mem[mid] < st.frac) lo = mid + 1;
            else hi = mid;
         end
      end
      r.sample_index   = lo[INDEX_W-1:0];
      r.drawn_fraction = st.frac;
      return r;
   endfunction

   task automatic push_write(input int idx, input logic [VALUE_W-1:0] val);
      req_word_type w;
      w.command     = CMD_WRITE;
      w.entry_index = idx[INDEX_W-1:0];
      w.entry_value = val;
      plan_table[idx] = val;
      pending_words = {pending_words, w};
      items_queued++;
   endtask

   task automatic push_draw();
      req_word_type w;
      w.command     = CMD_DRAW;
      w.entry_index = INDEX_W'($urandom_range(0, TB_DEPTH - 1));
      w.entry_value = VALUE_W'($urandom());
      plan_seed = draw_from(plan_seed).seed;
      pending_words = {pending_words, w};
      items_queued++;
   endtask

   // mostly keeps the table monotone, sometimes drops in an arbitrary value
   task automatic push_random_write(input int span);
      int idx;
      logic [VALUE_W-1:0] lo_val;
      logic [VALUE_W-1:0] hi_val;
      if (span > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, span - 1);
      else idx = $urandom_range(0, TB_DEPTH - 1);
      lo_val = (idx == 0) ? '0 : plan_table[idx-1];
      hi_val = (idx == TB_DEPTH - 1) ? ONE_FIXED : plan_table[idx+1];
      if (lo_val <= hi_val && $urandom_range(0, 6) != 0)
         push_write(idx, VALUE_W'($urandom_range(hi_val, lo_val)));
      else
         push_write(idx, VALUE_W'($urandom_range(0, MAX_VALUE)));
   endtask

   // wait for the block to go quiet before touching the register
   task automatic settle();
      int waited;
      waited = 0;
      while ((pending_words.size() != 0 || req_valid || expected_draws.size() != 0)
             && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_words.size() != 0 || expected_draws.size() != 0) begin
         $display("%0t: stuck with %0d words unsent, %0d results missing",
                  $time, pending_words.size(), expected_draws.size());
         fail_count++;
         expected_draws.delete();
      end
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   task automatic set_table_size(input logic [SIZE_W-1:0] size);
      csr_valid      <= 1'b1;
      csr_table_size <= size;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      model_size = size;
   endtask

   // driver: bursts of words with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            if (req_command == CMD_WRITE) begin
               if (req_entry_index < TB_DEPTH) weight_mem[req_entry_index] = req_entry_value;
            end else begin
               expected_draws = {expected_draws, predict_draw()};
            end
         end
         if (gap_left != 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_command     <= pending_words[0].command;
            req_entry_index <= pending_words[0].entry_index;
            req_entry_value <= pending_words[0].entry_value;
            req_valid       <= 1'b1;
            void'(pending_words.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 24);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: own stall pattern plus a few long hold-offs
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         recv_cycle <= recv_cycle + 1;
         if (recv_cycle[7:0] == 8'd0) stall_mode <= $urandom_range(0, 3);
         if (rsp_valid && !rsp_stall) taken_results <= taken_results + 1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall &&
                      (taken_results == 40 || taken_results == 250 || taken_results == 500)) begin
            hold_left <= 300;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= recv_cycle[0];
            endcase
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_draws.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual index %0d fraction %0d",
                     $time, rsp_sample_index, rsp_drawn_fraction);
            fail_count++;
         end else begin
            oldest_draw = expected_draws.pop_front();
            if (rsp_sample_index !== oldest_draw.sample_index) begin
               $display("%0t: sample_index expected %0d actual %0d",
                        $time, oldest_draw.sample_index, rsp_sample_index);
               fail_count++;
            end
            if (rsp_drawn_fraction !== oldest_draw.drawn_fraction) begin
               $display("%0t: drawn_fraction expected %0d actual %0d",
                        $time, oldest_draw.drawn_fraction, rsp_drawn_fraction);
               fail_count++;
            end
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_cdf_weighted_index_sampler failed");
      $finish;
   end

   initial begin : stimulus
      logic [VALUE_W-1:0] ramp[$];
      logic [FRAC_W-1:0]  next_frac;
      logic [SIZE_W-1:0]  size;
      int                 span;
      int                 n;
      int                 pick;
      for (int i = 0; i < TB_DEPTH; i++) begin
         weight_mem[i] = '0;
         plan_table[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset size of one; the first draw sees a zero fraction and redraws
      push_write(0, '0);
      push_draw();
      push_draw();
      push_write(0, MAX_VALUE);
      push_draw();
      push_write(TB_DEPTH - 1, MAX_VALUE);
      push_write(TB_DEPTH - 1, '0);
      settle();

      // empty search range
      set_table_size('0);
      push_draw();
      push_draw();
      settle();

      // full monotone table, top entries at and above one
      for (int i = 0; i < TB_DEPTH; i++) ramp = {ramp, VALUE_W'($urandom_range(0, ONE_FIXED))};
      ramp.sort();
      ramp[TB_DEPTH-4] = ONE_FIXED;
      ramp[TB_DEPTH-3] = 24'd9000000;
      ramp[TB_DEPTH-2] = 24'd12000000;
      ramp[TB_DEPTH-1] = MAX_VALUE;
      for (int i = 0; i < TB_DEPTH; i++) push_write(i, ramp[i]);
      settle();

      // size beyond the table depth clamps
      set_table_size({SIZE_W{1'b1}});
      repeat (30) push_draw();
      settle();

      // entry equal to the fraction, then one just below it
      set_table_size(11'd2);
      next_frac = draw_from(plan_seed).frac;
      push_write(0, VALUE_W'(next_frac));
      push_write(1, MAX_VALUE);
      push_draw();
      next_frac = draw_from(plan_seed).frac;
      push_write(0, VALUE_W'((next_frac == '0) ? '0 : next_frac - 1'b1));
      push_draw();
      settle();

      while (items_queued < ITEM_TARGET) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0: size = 11'd1024;
            1: size = 11'd1;
            2: size = 11'd1023;
            3: size = 11'd1025;
            4, 5: size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
            default: size = SIZE_W'($urandom_range(2, 64));
         endcase
         set_table_size(size);
         span = (size > TB_DEPTH) ? TB_DEPTH : size;
         n = $urandom_range(20, 80);
         repeat (n) begin
            if ($urandom_range(0, 9) < 7) push_draw();
            else push_random_write(span);
         end
         settle();
      end

      if (fail_count == 0) begin
         $display("tb_cdf_weighted_index_sampler passed");
      end else begin
         $display("tb_cdf_weighted_index_sampler failed");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/cwis_pkg.sv
hdl/cwis_ram.sv
hdl/cdf_weighted_index_sampler.sv
hdl/cwis_checker.sv
bench/tb_cdf_weighted_index_sampler.sv
